/* hdl/jet_pkg.sv */
// ----------------------------------------------------------------------------
// jet_pkg - shared types and constants for the Julia escape-time pixel engine
// Payload structs, configuration layout, register indexes and the saturation
// helper used by the start-value and iteration datapaths.
// ----------------------------------------------------------------------------
package jet_pkg;

    // Fixed-point format: signed Q4.28 in 32-bit words
    localparam int FRAC_BITS  = 28;
    localparam int ESC_SHIFT  = 2 * FRAC_BITS + 2;
    localparam int ITER_W     = 8;
    localparam logic [ITER_W-1:0] MAX_ITER = 8'd255;

    // Start-value queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Configuration register indexes
    localparam int CFG_ADDR_W = 3;
    localparam logic [CFG_ADDR_W-1:0] REG_ORIGIN_RE = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ORIGIN_IM = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_STEP      = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_C_RE      = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_C_IM      = 3'd4;

    // Reset values
    localparam logic [31:0] RST_ORIGIN_RE = 32'hE000_0000;
    localparam logic [31:0] RST_ORIGIN_IM = 32'hE000_0000;
    localparam logic [30:0] RST_STEP      = 31'd2236962;
    localparam logic [31:0] RST_C_RE      = 32'hF999_999A;
    localparam logic [31:0] RST_C_IM      = 32'h0999_999A;

    localparam logic signed [63:0] SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] SAT_MIN = 64'shFFFF_FFFF_8000_0000;

    typedef struct packed {
        logic [11:0] pixel_x;
        logic [11:0] pixel_y;
    } jet_in_t;

    typedef struct packed {
        logic [7:0] iterations;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } jet_out_t;

    typedef struct packed {
        logic [31:0] origin_re;
        logic [31:0] origin_im;
        logic [30:0] step;
        logic [31:0] c_re;
        logic [31:0] c_im;
    } jet_cfg_t;

    // One queued start value
    typedef struct packed {
        logic [31:0] zr;
        logic [31:0] zi;
    } jet_start_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_MUL,
        B_ADD,
        B_DONE
    } jet_bstate_t;

    // Clamp a 64-bit signed value to the signed 32-bit word
    function automatic logic [31:0] sat32(input logic signed [63:0] v);
        logic [31:0] r;
        if (v > SAT_MAX)
        begin
            r = SAT_MAX[31:0];
        end
        else if (v < SAT_MIN)
        begin
            r = SAT_MIN[31:0];
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

/* hdl/jet_front.sv */
// ----------------------------------------------------------------------------
// jet_front - start-value front end
// Accepts pixel beats, scales them by the step and offsets them by the
// origin, then pushes the saturated start value into the queue.
// ----------------------------------------------------------------------------
module jet_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pix_valid,
    output logic               pix_stall,
    input  jet_pkg::jet_in_t   pix,
    input  jet_pkg::jet_cfg_t  cfg,
    output logic               push,
    input  logic               push_ready,
    output jet_pkg::jet_start_t push_data
);
    import jet_pkg::*;

    logic        s1_valid_reg, s1_valid_next;
    logic [42:0] prod_x_reg, prod_x_next;
    logic [42:0] prod_y_reg, prod_y_next;
    logic        take;
    logic signed [63:0] sum_x, sum_y;

    assign push      = s1_valid_reg && push_ready;
    assign pix_stall = s1_valid_reg && !push_ready;
    assign take      = pix_valid && !pix_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        prod_x_next   = prod_x_reg;
        prod_y_next   = prod_y_reg;
        if (push)
        begin
            s1_valid_next = 1'b0;
        end
        if (take)
        begin
            s1_valid_next = 1'b1;
            prod_x_next   = 43'(pix.pixel_x) * 43'(cfg.step);
            prod_y_next   = 43'(pix.pixel_y) * 43'(cfg.step);
        end
    end

    // exact sum of origin and scaled pixel, then clamp
    always_comb
    begin
        sum_x = $signed({{32{cfg.origin_re[31]}}, cfg.origin_re})
              + $signed({21'b0, prod_x_reg});
        sum_y = $signed({{32{cfg.origin_im[31]}}, cfg.origin_im})
              + $signed({21'b0, prod_y_reg});
        push_data.zr = sat32(sum_x);
        push_data.zi = sat32(sum_y);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_x_reg <= prod_x_next;
        prod_y_reg <= prod_y_next;
    end

endmodule

/* hdl/jet_queue.sv */
// ----------------------------------------------------------------------------
// jet_queue - short start-value queue
// Decouples the front end from the iteration engine so each can stall alone.
// ----------------------------------------------------------------------------
module jet_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                push_ready,
    input  jet_pkg::jet_start_t push_data,
    input  logic                pop,
    output logic                pop_valid,
    output jet_pkg::jet_start_t pop_data
);
    import jet_pkg::*;

    jet_start_t        mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign push_ready = (count_reg != QCNT_W'(QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;
    assign pop_data   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* hdl/jet_back.sv */
// ----------------------------------------------------------------------------
// jet_back - iteration engine and palette
// Iterates z = z*z + c, each step a multiply state and then an update and
// escape-test state, then maps the count to a colour into the output register.
// ----------------------------------------------------------------------------
module jet_back (
    input  logic                clk,
    input  logic                rst_n,
    input  jet_pkg::jet_cfg_t   cfg,
    output logic                pop,
    input  logic                pop_valid,
    input  jet_pkg::jet_start_t pop_data,
    output logic                res_valid,
    input  logic                res_stall,
    output jet_pkg::jet_out_t   res
);
    import jet_pkg::*;

    jet_bstate_t        state_reg, state_next;
    logic [31:0]        zr_reg, zr_next;
    logic [31:0]        zi_reg, zi_next;
    logic signed [63:0] sr_reg, sr_next;
    logic signed [63:0] si_reg, si_next;
    logic signed [63:0] sx_reg, sx_next;
    logic [ITER_W-1:0]  iter_reg, iter_next;
    logic               res_valid_reg, res_valid_next;
    jet_out_t           res_reg, res_next;

    logic [63:0]        mag_sum;
    logic signed [63:0] re_full, im_full;
    logic               escape;
    logic               out_free;
    jet_out_t           colour;

    // palette working values
    logic [10:0] p1_b;
    logic [6:0]  p2_t;
    logic [30:0] p2_g, p2_q;
    logic [7:0]  p3_t;
    logic [15:0] p3_r, p3_g;

    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign out_free  = !res_valid_reg || !res_stall;

    // update and escape test on registered products
    always_comb
    begin
        mag_sum = $unsigned(sr_reg) + $unsigned(si_reg);
        escape  = (mag_sum >> ESC_SHIFT) != 64'd0;
        re_full = ((sr_reg - si_reg) >>> FRAC_BITS)
                + $signed({{32{cfg.c_re[31]}}, cfg.c_re});
        im_full = (sx_reg >>> (FRAC_BITS - 1))
                + $signed({{32{cfg.c_im[31]}}, cfg.c_im});
    end

    // piecewise-linear palette: stops 0, 12, 127, 255
    always_comb
    begin
        p1_b = (11'd85 * 11'(iter_reg)) >> 2;
        p2_t = 7'(iter_reg - 8'd12);
        p2_g = (31'd36473 * (31'd192 * 31'(p2_t))) >> 22;
        p2_q = (31'd36473 * (31'd63 * 31'(p2_t))) >> 22;
        p3_t = iter_reg - 8'd127;
        p3_r = (16'd255 * 16'(p3_t)) >> 7;
        p3_g = 16'd192 + ((16'd63 * 16'(p3_t)) >> 7);
        colour.iterations = iter_reg;
        if (iter_reg <= 8'd12)
        begin
            colour.red   = 8'd0;
            colour.green = 8'd0;
            colour.blue  = p1_b[7:0];
        end
        else if (iter_reg <= 8'd127)
        begin
            colour.red   = 8'd0;
            colour.green = p2_g[7:0];
            colour.blue  = 8'd255 - p2_q[7:0];
        end
        else
        begin
            colour.red   = p3_r[7:0];
            colour.green = p3_g[7:0];
            colour.blue  = p3_g[7:0];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        zr_next        = zr_reg;
        zi_next        = zi_reg;
        sr_next        = sr_reg;
        si_next        = si_reg;
        sx_next        = sx_reg;
        iter_next      = iter_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        pop            = 1'b0;

        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            B_IDLE:
            begin
                if (pop_valid)
                begin
                    pop        = 1'b1;
                    zr_next    = pop_data.zr;
                    zi_next    = pop_data.zi;
                    iter_next  = '0;
                    state_next = B_MUL;
                end
            end
            B_MUL:
            begin
                if (iter_reg == MAX_ITER)
                begin
                    state_next = B_DONE;
                end
                else
                begin
                    sr_next    = 64'($signed(zr_reg)) * 64'($signed(zr_reg));
                    si_next    = 64'($signed(zi_reg)) * 64'($signed(zi_reg));
                    sx_next    = 64'($signed(zr_reg)) * 64'($signed(zi_reg));
                    state_next = B_ADD;
                end
            end
            B_ADD:
            begin
                if (escape)
                begin
                    state_next = B_DONE;
                end
                else
                begin
                    zr_next    = sat32(re_full);
                    zi_next    = sat32(im_full);
                    iter_next  = iter_reg + 1'b1;
                    state_next = B_MUL;
                end
            end
            B_DONE:
            begin
                if (out_free)
                begin
                    res_next       = colour;
                    res_valid_next = 1'b1;
                    state_next     = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        zr_reg   <= zr_next;
        zi_reg   <= zi_next;
        sr_reg   <= sr_next;
        si_reg   <= si_next;
        sx_reg   <= sx_next;
        iter_reg <= iter_next;
        res_reg  <= res_next;
    end

endmodule

/* hdl/julia_escape_time_pixel_top.sv */
// ----------------------------------------------------------------------------
// julia_escape_time_pixel_top - Julia-set escape-time pixel engine
// Maps a pixel to its start value, iterates z = z*z + c in Q4.28 until
// |z|^2 reaches 4 or 255 steps are done, and returns the count with a colour.
// ----------------------------------------------------------------------------
//
//  channel | signals                     | beat moves
//  --------+-----------------------------+----------------------------------
//  pixel   | pix_valid, pix_stall, pix   | one pixel column/row pair
//  result  | res_valid, res_stall, res   | iteration count and RGB colour
//  config  | cfg_en, cfg_addr, cfg_data  | one register write, no wait
//
//  From acceptance a pixel is scaled into the front-end product registers,
//  written into the queue, loaded by the engine, run through the
//  multiply/update loop until it escapes or reaches the limit, and coloured
//  into the output register. The loop sets the rate.
//  Reset clears all handshake state and loads the default view and constant.
//  A stalled result holds in the output register while the next pixel runs.
// ----------------------------------------------------------------------------
module julia_escape_time_pixel_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           pix_valid,
    output logic                           pix_stall,
    input  jet_pkg::jet_in_t               pix,
    output logic                           res_valid,
    input  logic                           res_stall,
    output jet_pkg::jet_out_t              res,
    input  logic                           cfg_en,
    input  logic [jet_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [31:0]                    cfg_data
);
    import jet_pkg::*;

    jet_cfg_t   cfg_reg, cfg_next;
    logic       push, push_ready, pop, pop_valid;
    jet_start_t push_data, pop_data;

    // register file: unknown indexes drop the write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_en)
        begin
            case (cfg_addr)
                REG_ORIGIN_RE: cfg_next.origin_re = cfg_data;
                REG_ORIGIN_IM: cfg_next.origin_im = cfg_data;
                REG_STEP:      cfg_next.step      = cfg_data[30:0];
                REG_C_RE:      cfg_next.c_re      = cfg_data;
                REG_C_IM:      cfg_next.c_im      = cfg_data;
                default:       cfg_next           = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.origin_re <= RST_ORIGIN_RE;
            cfg_reg.origin_im <= RST_ORIGIN_IM;
            cfg_reg.step      <= RST_STEP;
            cfg_reg.c_re      <= RST_C_RE;
            cfg_reg.c_im      <= RST_C_IM;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // front end: scale and offset each pixel beat
    jet_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix_valid  (pix_valid),
        .pix_stall  (pix_stall),
        .pix        (pix),
        .cfg        (cfg_reg),
        .push       (push),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // hold start values while the engine is busy
    jet_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop        (pop),
        .pop_valid  (pop_valid),
        .pop_data   (pop_data)
    );

    // back end: iterate, colour, present the result beat
    jet_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .pop        (pop),
        .pop_valid  (pop_valid),
        .pop_data   (pop_data),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res        (res)
    );

`ifndef NO_ASSERTIONS
    // count zero is the black stop
    a_black_stop: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.iterations == 8'd0
        |-> res.red == 8'd0 && res.green == 8'd0 && res.blue == 8'd0)
        else $error("count zero must map to black");

    // a pixel that never escaped is white
    a_white_stop: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.iterations == MAX_ITER
        |-> res.red == 8'd255 && res.green == 8'd255 && res.blue == 8'd255)
        else $error("iteration limit must map to white");

    // below the teal stop there is no red
    a_no_red_low: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.iterations <= 8'd127 |-> res.red == 8'd0)
        else $error("red must stay zero up to the teal stop");
`endif

endmodule
